// ===== hdl/etd_pkg.sv =====
// Shared types and constants for the EDID detailed timing descriptor decoder.
`timescale 1ns / 1ps

package etd_pkg;

   localparam int BITS_PER_PIXEL  = 32;
   localparam int BYTES_PER_PIXEL = BITS_PER_PIXEL / 8;

   localparam int CLK_IN_W   = 16;
   localparam int KHZ_W      = 20;
   localparam int COUNT_W    = 12;
   localparam int TOTAL_W    = COUNT_W + 1;
   localparam int H_SYNC_W   = 10;
   localparam int V_SYNC_W   = 6;
   localparam int FLAGS_W    = 4;
   localparam int LINE_W     = 14;
   localparam int REFRESH_W  = 30;
   localparam int DIVISOR_W  = 2 * TOTAL_W;
   localparam int REM_W      = DIVISOR_W + 1;

   // 10 kHz units to kHz, and 10 kHz units to Hz
   localparam int KHZ_PER_UNIT = 10;
   localparam int HZ_PER_UNIT  = 10000;

   // divider: one quotient bit per step, a few steps per register stage
   localparam int DIV_STEPS       = REFRESH_W;
   localparam int STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES      = (DIV_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

   // mode_flags bit positions
   localparam int FLAG_VALID     = 0;
   localparam int FLAG_INTERLACE = 1;
   localparam int FLAG_VSYNC_POS = 2;
   localparam int FLAG_HSYNC_POS = 3;

   // feature_bits bit positions
   localparam int FEAT_INTERLACE = 7;
   localparam int FEAT_VSYNC_POS = 2;
   localparam int FEAT_HSYNC_POS = 1;

   typedef struct packed {
      logic [CLK_IN_W-1:0] clock_10khz;
      logic [7:0]          h_active_low;
      logic [7:0]          h_blank_low;
      logic [7:0]          h_upper_nibbles;
      logic [7:0]          v_active_low;
      logic [7:0]          v_blank_low;
      logic [7:0]          v_upper_nibbles;
      logic [7:0]          h_front_low;
      logic [7:0]          h_width_low;
      logic [7:0]          v_sync_nibbles;
      logic [7:0]          sync_upper_bits;
      logic [7:0]          feature_bits;
   } req_type;

   typedef struct packed {
      logic [KHZ_W-1:0]     clock_khz;
      logic [COUNT_W-1:0]   h_active_px;
      logic [COUNT_W-1:0]   h_blank_px;
      logic [H_SYNC_W-1:0]  h_sync_front;
      logic [H_SYNC_W-1:0]  h_sync_width;
      logic [COUNT_W-1:0]   v_active_lines;
      logic [COUNT_W-1:0]   v_blank_lines;
      logic [V_SYNC_W-1:0]  v_sync_front;
      logic [V_SYNC_W-1:0]  v_sync_width;
      logic [FLAGS_W-1:0]   mode_flags;
      logic [LINE_W-1:0]    line_bytes;
      logic [REFRESH_W-1:0] refresh_rate;
   } rsp_type;

   // after unpack: decoded fields plus the refresh operands
   typedef struct packed {
      rsp_type              rsp;
      logic [REFRESH_W-1:0] dividend;
      logic [TOTAL_W-1:0]   h_total;
      logic [TOTAL_W-1:0]   v_total;
   } front_type;

   // divider state: quotient bits shift in as dividend bits shift out of nq
   typedef struct packed {
      logic [DIVISOR_W-1:0] divisor;
      logic [REM_W-1:0]     rem;
      logic [REFRESH_W-1:0] nq;
   } div_type;

   typedef struct packed {
      rsp_type rsp;
      div_type div;
   } pipe_type;

endpackage

// ===== hdl/etd_unpack.sv =====
// Stage one: joins descriptor bytes into fields, forms totals and the dividend.
`timescale 1ns / 1ps

module etd_unpack
   import etd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  req_type   in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output front_type out_data
);

   logic      valid_ff, valid_in;
   front_type data_ff, data_in;

   logic [COUNT_W-1:0] h_act, h_blk, v_act, v_blk;

   always_comb begin
      h_act = {in_data.h_upper_nibbles[7:4], in_data.h_active_low};
      h_blk = {in_data.h_upper_nibbles[3:0], in_data.h_blank_low};
      v_act = {in_data.v_upper_nibbles[7:4], in_data.v_active_low};
      v_blk = {in_data.v_upper_nibbles[3:0], in_data.v_blank_low};

      data_in = '0;
      if (in_data.clock_10khz != '0) begin
         data_in.rsp.clock_khz      = KHZ_W'(in_data.clock_10khz) * KHZ_W'(KHZ_PER_UNIT);
         data_in.rsp.h_active_px    = h_act;
         data_in.rsp.h_blank_px     = h_blk;
         data_in.rsp.h_sync_front   = {in_data.sync_upper_bits[7:6], in_data.h_front_low};
         data_in.rsp.h_sync_width   = {in_data.sync_upper_bits[5:4], in_data.h_width_low};
         data_in.rsp.v_active_lines = v_act;
         data_in.rsp.v_blank_lines  = v_blk;
         data_in.rsp.v_sync_front   = {in_data.sync_upper_bits[3:2],
                                       in_data.v_sync_nibbles[7:4]};
         data_in.rsp.v_sync_width   = {in_data.sync_upper_bits[1:0],
                                       in_data.v_sync_nibbles[3:0]};
         data_in.rsp.mode_flags[FLAG_VALID]     = 1'b1;
         data_in.rsp.mode_flags[FLAG_INTERLACE] = in_data.feature_bits[FEAT_INTERLACE];
         data_in.rsp.mode_flags[FLAG_VSYNC_POS] = in_data.feature_bits[FEAT_VSYNC_POS];
         data_in.rsp.mode_flags[FLAG_HSYNC_POS] = in_data.feature_bits[FEAT_HSYNC_POS];
         data_in.rsp.line_bytes     = LINE_W'(h_act) * LINE_W'(BYTES_PER_PIXEL);
         data_in.dividend = REFRESH_W'(in_data.clock_10khz) * REFRESH_W'(HZ_PER_UNIT);
         data_in.h_total  = TOTAL_W'(h_act) + TOTAL_W'(h_blk);
         data_in.v_total  = TOTAL_W'(v_act) + TOTAL_W'(v_blk);
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hdl/etd_mult.sv =====
// Stage two: frame size product htotal * vtotal, divider setup.
`timescale 1ns / 1ps

module etd_mult
   import etd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  front_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output pipe_type  out_data
);

   logic     valid_ff, valid_in;
   pipe_type data_ff, data_in;

   logic [DIVISOR_W-1:0] frame_px;

   always_comb begin
      frame_px = DIVISOR_W'(in_data.h_total) * DIVISOR_W'(in_data.v_total);
      data_in.rsp     = in_data.rsp;
      data_in.div.rem = '0;
      // zero total: divide 0 by 1 so refresh comes out zero
      if (frame_px == '0) begin
         data_in.div.divisor = DIVISOR_W'(1);
         data_in.div.nq      = '0;
      end else begin
         data_in.div.divisor = frame_px;
         data_in.div.nq      = in_data.dividend;
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hdl/etd_div_stage.sv =====
// One divider stage: a few restoring quotient-bit steps, then a register.
`timescale 1ns / 1ps

module etd_div_stage
   import etd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  pipe_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output pipe_type out_data
);

   function automatic div_type div_step(input div_type d);
      logic [REM_W-1:0] rem_sh;
      logic             ge;
      div_type          r;
      rem_sh    = {d.rem[REM_W-2:0], d.nq[REFRESH_W-1]};
      ge        = rem_sh >= {1'b0, d.divisor};
      r.divisor = d.divisor;
      r.rem     = ge ? rem_sh - {1'b0, d.divisor} : rem_sh;
      r.nq      = {d.nq[REFRESH_W-2:0], ge};
      return r;
   endfunction

   logic     valid_ff, valid_in;
   pipe_type data_ff, data_in;

   always_comb begin
      data_in = in_data;
      for (int s = 0; s < STEPS_PER_STAGE; s++) begin
         data_in.div = div_step(data_in.div);
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hdl/edid_timing_descriptor_decode.sv =====
// EDID detailed timing descriptor decoder, top level.
// Stages: unpack, multiply, then DIV_STAGES divider stages (30-bit refresh quotient, 2 bits per stage).
// Throughput: one item per cycle unless rsp_ready is low; every stage holds its own valid and
// stalls only when full with no ready from the next, so bubbles close up under backpressure.
// Reset: synchronous, active high; clears all stage valid bits, payload is not reset.
`timescale 1ns / 1ps

module edid_timing_descriptor_decode
   import etd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   // unpack -> multiply handshake
   logic      front_valid, front_ready;
   front_type front_data;

   // divider chain: index 0 is the multiply stage output, last index is the result
   logic     div_valid [DIV_STAGES+1];
   logic     div_ready [DIV_STAGES+1];
   pipe_type div_data  [DIV_STAGES+1];

   // stage 1: byte joining, pixel clock scaling, totals, refresh dividend
   etd_unpack u_unpack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_payload),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   // stage 2: htotal * vtotal; a zero product turns into 0 / 1
   etd_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (div_valid[0]),
      .out_ready (div_ready[0]),
      .out_data  (div_data[0])
   );

   // refresh = dividend / frame pixels, restoring division spread over DIV_STAGES
   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      etd_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[g]),
         .in_ready  (div_ready[g]),
         .in_data   (div_data[g]),
         .out_valid (div_valid[g+1]),
         .out_ready (div_ready[g+1]),
         .out_data  (div_data[g+1])
      );
   end

   // last divider stage register doubles as the output register
   assign rsp_valid             = div_valid[DIV_STAGES];
   assign div_ready[DIV_STAGES] = rsp_ready;

   always_comb begin
      rsp_payload              = div_data[DIV_STAGES].rsp;
      rsp_payload.refresh_rate = div_data[DIV_STAGES].div.nq;
   end

endmodule
